// ===== rtl/tstk_pkg.sv =====
// Package for the timestamp text to ticks parser.
// Holds the parse state type, the scaled term type and the character and tick constants.
// No dependencies.
package tstk_pkg;

  // Character codes
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Tick scale factors (100 us per tick)
  localparam logic [31:0] TICKS_PER_HOUR = 32'd36000000;
  localparam logic [31:0] TICKS_PER_MIN  = 32'd600000;
  localparam logic [31:0] TICKS_PER_SEC  = 32'd10000;

  // Colon count saturates here; reaching it is an error
  localparam logic [1:0] COLONS_MAX = 2'd3;
  localparam logic [1:0] COLONS_HMS = 2'd2;
  localparam logic [1:0] COLONS_NONE = 2'd0;

  // Fraction digit bookkeeping
  localparam logic [2:0] FRAC_KEEP   = 3'd4;
  localparam logic [2:0] FRAC_ROUNDED = 3'd5;
  localparam logic [3:0] ROUND_DIGIT = 4'd5;

  // Running parse state, also the snapshot handed on at the last character
  typedef struct packed {
    logic [31:0] current;
    logic [31:0] previous;
    logic [31:0] oldest;
    logic [1:0]  colons;
    logic        closed;
    logic        dot;
    logic [13:0] frac_value;
    logic [2:0]  frac_digits;
    logic        round_up;
    logic        colon_after_dot;
  } tstk_state_t;

  // Scaled terms of one result, summed by the output stage
  typedef struct packed {
    logic [31:0] hr_term;
    logic [31:0] min_term;
    logic [31:0] sec_term;
    logic [13:0] frac_term;
    logic        err;
  } tstk_terms_t;

endpackage

// ===== rtl/timestamp_text_to_ticks.sv =====
// Timestamp text to ticks: top level with the summing output register.
// Instantiates tstk_parser and tstk_scale; uses tstk_pkg.
//
// Input channel: one character word per handshake (char_code_i, last_char_i)
// on in_valid_i / in_ready_o. Forms: ticks, sec.frac, min:sec[.frac] and
// hr:min:sec[.frac]. Only the word marked last_char_i yields a result.
// Output channel: tick_count_o (100 us ticks, modulo 2^32) and parse_error_o
// on out_valid_o / out_ready_i; on error the tick count is zero.
// Throughput: one character word per cycle while in_ready_o is high, strings back to back.
// Pipeline: three register stages (parser snapshot, scaled terms, output);
// the result passes through each in turn after the last character is
// accepted. Each stage holds its word while the next is occupied, so a
// stalled receiver fills the stages and in_ready_o then drops; characters
// that are not last still wait for the snapshot stage to be free.
// Reset clears the parse state and all valid flags; no words are in flight.
module timestamp_text_to_ticks (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] tick_count_o,
  output logic        parse_error_o
);
  import tstk_pkg::*;

  tstk_state_t snap;
  logic        snap_valid, snap_ready;
  tstk_terms_t terms;
  logic        terms_valid, terms_ready;

  logic        out_valid_q, out_valid_d;
  logic [31:0] tick_q, tick_d;
  logic        err_q;
  logic        sum_accept;

  tstk_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  tstk_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .snap_valid_i  (snap_valid),
    .snap_ready_o  (snap_ready),
    .snap_i        (snap),
    .terms_valid_o (terms_valid),
    .terms_ready_i (terms_ready),
    .terms_o       (terms)
  );

  // Output stage: sum of the four terms
  assign terms_ready = !out_valid_q || out_ready_i;
  assign sum_accept  = terms_valid && terms_ready;

  always_comb begin
    tick_d      = 32'(terms.hr_term + terms.min_term + terms.sec_term
                      + 32'(terms.frac_term));
    out_valid_d = (out_valid_q && !out_ready_i) || sum_accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (sum_accept) begin
      tick_q <= tick_d;
      err_q  <= terms.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tick_count_o  = tick_q;
  assign parse_error_o = err_q;

`ifndef SYNTH
  a_err_zero_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_error_o |-> tick_count_o == 32'd0)
    else $error("error word carries a nonzero tick count");

  a_err_zero_terms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    terms_valid && terms.err |-> (terms.hr_term == 32'd0) && (terms.min_term == 32'd0)
      && (terms.sec_term == 32'd0) && (terms.frac_term == 14'd0))
    else $error("error word carries nonzero terms");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    terms_valid |-> terms.frac_term <= 14'd10000)
    else $error("scaled fraction out of range");

  a_terms_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    terms_valid && !terms_ready |=> terms_valid && $stable(terms))
    else $error("terms stage dropped or changed a blocked word");
`endif

endmodule

// ===== rtl/tstk_parser.sv =====
// Character parser: updates the field state once per accepted word and hands a
// snapshot of the final state onward on the last character. Uses tstk_pkg.
module tstk_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic                last_char_i,
  output logic                snap_valid_o,
  input  logic                snap_ready_i,
  output tstk_pkg::tstk_state_t snap_o
);
  import tstk_pkg::*;

  tstk_state_t st_q, st_d, nxt;
  tstk_state_t snap_q;
  logic        snap_valid_q, snap_valid_d;
  logic        accept;
  logic        is_digit;
  logic [3:0]  digit;

  assign in_ready_o = !snap_valid_q || snap_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next parse state for the incoming character
  always_comb begin
    is_digit = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
    digit    = is_digit ? 4'(char_code_i - CHAR_ZERO) : 4'd0;
    nxt      = st_q;
    if (char_code_i == CHAR_COLON) begin
      if (st_q.colons != COLONS_MAX) nxt.colons = st_q.colons + 2'd1;
      if (st_q.dot) begin
        nxt.colon_after_dot = 1'b1;
      end else begin
        nxt.oldest   = st_q.previous;
        nxt.previous = st_q.current;
        nxt.current  = '0;
        nxt.closed   = 1'b0;
      end
    end else if (!st_q.dot) begin
      if (char_code_i == CHAR_DOT) begin
        nxt.dot    = 1'b1;
        nxt.closed = 1'b0;
      end else if (is_digit) begin
        if (!st_q.closed) nxt.current = 32'(st_q.current * 32'd10) + 32'(digit);
      end else begin
        nxt.closed = 1'b1;
      end
    end else if (!is_digit) begin
      nxt.closed = 1'b1;
    end else if (!st_q.closed) begin
      if (st_q.frac_digits < FRAC_KEEP) begin
        nxt.frac_value  = 14'(st_q.frac_value * 14'd10) + 14'(digit);
        nxt.frac_digits = st_q.frac_digits + 3'd1;
      end else if (st_q.frac_digits == FRAC_KEEP) begin
        nxt.round_up    = (digit >= ROUND_DIGIT);
        nxt.frac_digits = FRAC_ROUNDED;
      end
    end
  end

  // State clears after each string
  always_comb begin
    st_d = st_q;
    if (accept) st_d = last_char_i ? '0 : nxt;
    snap_valid_d = (snap_valid_q && !snap_ready_i) || (accept && last_char_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      st_q         <= st_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  // Snapshot payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && last_char_i) snap_q <= nxt;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// ===== rtl/tstk_scale.sv =====
// Scaling stage: multiplies each field by its tick factor and scales the fraction.
// Takes the parser snapshot, registers the terms. Uses tstk_pkg.
module tstk_scale (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  snap_valid_i,
  output logic                  snap_ready_o,
  input  tstk_pkg::tstk_state_t snap_i,
  output logic                  terms_valid_o,
  input  logic                  terms_ready_i,
  output tstk_pkg::tstk_terms_t terms_o
);
  import tstk_pkg::*;

  tstk_terms_t terms_q, terms_d;
  logic        terms_valid_q, terms_valid_d;
  logic        accept;
  logic [13:0] frac_scaled;

  assign snap_ready_o = !terms_valid_q || terms_ready_i;
  assign accept       = snap_valid_i && snap_ready_o;

  // Fraction padded to four digits, then rounded
  always_comb begin
    case (snap_i.frac_digits)
      3'd1:    frac_scaled = 14'(snap_i.frac_value * 14'd1000);
      3'd2:    frac_scaled = 14'(snap_i.frac_value * 14'd100);
      3'd3:    frac_scaled = 14'(snap_i.frac_value * 14'd10);
      3'd0:    frac_scaled = '0;
      default: frac_scaled = snap_i.frac_value;
    endcase
  end

  // Field products; an error result carries all zero terms
  always_comb begin
    terms_d.err       = (snap_i.colons == COLONS_MAX) || snap_i.colon_after_dot;
    terms_d.hr_term   = (snap_i.colons == COLONS_HMS) ?
                        32'(snap_i.oldest * TICKS_PER_HOUR) : '0;
    terms_d.min_term  = (snap_i.colons != COLONS_NONE) ?
                        32'(snap_i.previous * TICKS_PER_MIN) : '0;
    // bare tick count when there is neither colon nor dot
    terms_d.sec_term  = ((snap_i.colons == COLONS_NONE) && !snap_i.dot) ?
                        snap_i.current : 32'(snap_i.current * TICKS_PER_SEC);
    terms_d.frac_term = frac_scaled + 14'(snap_i.round_up);
    if (terms_d.err) begin
      terms_d.hr_term   = '0;
      terms_d.min_term  = '0;
      terms_d.sec_term  = '0;
      terms_d.frac_term = '0;
    end
    terms_valid_d = (terms_valid_q && !terms_ready_i) || accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) terms_valid_q <= 1'b0;
    else         terms_valid_q <= terms_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) terms_q <= terms_d;
  end

  assign terms_valid_o = terms_valid_q;
  assign terms_o       = terms_q;

endmodule

// ===== bench/timestamp_text_to_ticks_tb.sv =====
`timescale 1ns / 100ps
// Testbench for timestamp_text_to_ticks: streams time text one character word at a time
// and checks every tick count and error flag against an in-bench parser model.
// Depends on tstk_pkg and the timestamp_text_to_ticks RTL.
module timestamp_text_to_ticks_tb;
  import tstk_pkg::*;

  localparam int ITEMS       = 1100;
  localparam int QUIET_FROM  = 950;
  localparam int DRAIN_AT    = 600;
  localparam int HOLD_CYCLES = 90;
  localparam int LIMIT       = 400000;
  localparam int SETTLE      = 8;

  typedef struct {
    bit [31:0] ticks;
    bit        err;
  } tick_word_t;

  // Parser model plus the queue of tick words still owed by the block
  class tick_scoreboard;
    bit [31:0]  current;
    bit [31:0]  previous;
    bit [31:0]  oldest;
    bit [1:0]   colons;
    bit         closed;
    bit         dot;
    bit [13:0]  frac_value;
    bit [2:0]   frac_digits;
    bit         round_up;
    bit         colon_after_dot;
    tick_word_t owed_times[$];
    int         mismatches;

    function void clear_parse();
      current = '0;
      previous = '0;
      oldest = '0;
      colons = COLONS_NONE;
      closed = 1'b0;
      dot = 1'b0;
      frac_value = '0;
      frac_digits = '0;
      round_up = 1'b0;
      colon_after_dot = 1'b0;
    endfunction

    function void parse_char(bit [7:0] ch);
      bit       is_digit;
      bit [3:0] d;
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      d = is_digit ? 4'(ch - CHAR_ZERO) : 4'd0;
      if (ch == CHAR_COLON) begin
        if (colons != COLONS_MAX) colons++;
        if (dot) begin
          colon_after_dot = 1'b1;
        end else begin
          oldest = previous;
          previous = current;
          current = '0;
          closed = 1'b0;
        end
      end else if (!dot) begin
        if (ch == CHAR_DOT) begin
          dot = 1'b1;
          closed = 1'b0;
        end else if (is_digit) begin
          if (!closed) current = current * 10 + d;
        end else begin
          closed = 1'b1;
        end
      end else if (!is_digit) begin
        closed = 1'b1;
      end else if (!closed) begin
        // four digits kept, the fifth only decides rounding
        if (frac_digits < FRAC_KEEP) begin
          frac_value = frac_value * 10 + d;
          frac_digits++;
        end else if (frac_digits == FRAC_KEEP) begin
          round_up = (d >= ROUND_DIGIT);
          frac_digits = FRAC_ROUNDED;
        end
      end
    endfunction

    function tick_word_t close_string();
      tick_word_t w;
      bit [31:0]  frac;
      frac = frac_value;
      for (int n = frac_digits; n < FRAC_KEEP; n++) frac = frac * 10;
      frac = frac + round_up;
      w.err = (colons == COLONS_MAX) || colon_after_dot;
      if (w.err) begin
        w.ticks = '0;
      end else if (colons == COLONS_NONE) begin
        w.ticks = dot ? current * TICKS_PER_SEC + frac : current;
      end else if (colons == COLONS_HMS) begin
        w.ticks = oldest * TICKS_PER_HOUR + previous * TICKS_PER_MIN
                + current * TICKS_PER_SEC + frac;
      end else begin
        w.ticks = previous * TICKS_PER_MIN + current * TICKS_PER_SEC + frac;
      end
      return w;
    endfunction

    // Accepted input word
    function void note_char(bit [7:0] ch, bit last);
      parse_char(ch);
      if (last) begin
        owed_times.push_back(close_string());
        clear_parse();
      end
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Accepted output word
    task check_result(bit [31:0] ticks, bit err);
      tick_word_t w;
      if (owed_times.size() == 0) begin
        report("unexpected word, tick_count", ticks, 0);
      end else begin
        w = owed_times.pop_front();
        if (ticks !== w.ticks) report("tick_count", ticks, w.ticks);
        if (err !== w.err) report("parse_error", err, w.err);
      end
    endtask

    function int pending();
      return owed_times.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_code_i;
  logic        last_char_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] tick_count_o;
  logic        parse_error_o;

  tick_scoreboard sb;
  logic [7:0]     line_chars[$];
  int             chars_sent;
  int             tx_rate;
  int             cycles;
  bit             noise_on;
  bit             hold_req;
  bit             quiet_end;

  timestamp_text_to_ticks DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tick_count_o (tick_count_o),
    .parse_error_o(parse_error_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall bursts, one long hold on request, none near the end
  initial begin
    int stall_left;
    int rate;
    int span;
    stall_left = 0;
    rate = 0;
    span = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        span = $urandom_range(50, 250);
        case ($urandom_range(0, 2))
          0: rate = 0;
          1: rate = 4;
          default: rate = 16;
        endcase
      end
      span--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_end && rate != 0 && $urandom_range(1, rate) == 1) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(tick_count_o, parse_error_o);
  end

  // One character word; called and returns at a falling edge, valid left high
  task automatic send_char(logic [7:0] ch, logic last);
    if (chars_sent >= QUIET_FROM) quiet_end = 1'b1;
    if (!quiet_end && tx_rate != 0 && $urandom_range(1, tx_rate) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= ch;
    last_char_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_char(ch, last);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    for (int i = 0; i < line_chars.size(); i++)
      send_char(line_chars[i], i == line_chars.size() - 1);
  endtask

  task automatic set_text(string s);
    line_chars.delete();
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endtask

  // Optional stray byte ahead of each character in noisy strings
  task automatic push_char(logic [7:0] ch);
    if (noise_on && $urandom_range(0, 5) == 0) line_chars.push_back(8'($urandom_range(0, 255)));
    line_chars.push_back(ch);
  endtask

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly short fields, some empty, a few long enough to wrap
  function automatic int field_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r <= 7) return $urandom_range(1, 3);
    if (r == 8) return $urandom_range(4, 6);
    return $urandom_range(7, 12);
  endfunction

  task automatic make_random_text();
    int  kind;
    int  nfields;
    int  ndig;
    bit  nines;
    line_chars.delete();
    kind = $urandom_range(0, 99);
    noise_on = (kind >= 70) && (kind < 85);
    if (kind >= 85) begin
      // broken: loose mix of digits, separators and any byte
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 3))
          0: push_char(rand_digit());
          1: push_char(CHAR_COLON);
          2: push_char(CHAR_DOT);
          default: push_char(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      nfields = $urandom_range(0, 2);
      for (int f = 0; f <= nfields; f++) begin
        repeat (field_len()) push_char(rand_digit());
        if (f < nfields) push_char(CHAR_COLON);
      end
      if ($urandom_range(0, 1)) begin
        push_char(CHAR_DOT);
        ndig = $urandom_range(0, 7);
        nines = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < ndig; i++) push_char((nines && i < 4) ? "9" : rand_digit());
      end
    end
    if (line_chars.size() == 0) line_chars.push_back(rand_digit());
  endtask

  // Stimulus
  initial begin
    bit drained_once;
    sb = new();
    sb.clear_parse();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    char_code_i = '0;
    last_char_i = 1'b0;
    chars_sent = 0;
    tx_rate = 0;
    noise_on = 1'b0;
    hold_req = 1'b0;
    quiet_end = 1'b0;
    drained_once = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: hr:min:sec with carry, sixth digit and second dot
    set_text("1:2:3.999956.9");
    send_text();
    // too many colons, colon after the dot
    set_text(":::");
    send_text();
    set_text(".5:");
    send_text();
    // empty seconds field with fraction
    set_text("9:.5");
    send_text();
    // NUL and 0xFF as plain non-digits closing a ticks field
    line_chars.delete();
    line_chars.push_back(8'h00);
    line_chars.push_back("4");
    line_chars.push_back(8'hFF);
    line_chars.push_back("2");
    send_text();

    // Random: receiver holds off long while words keep coming
    hold_req = 1'b1;
    while (chars_sent < ITEMS) begin
      if (chars_sent < 200) tx_rate = 0;
      else if ((chars_sent / 100) % 3 == 0) tx_rate = 0;
      else if ((chars_sent / 100) % 3 == 1) tx_rate = 3;
      else tx_rate = 12;
      make_random_text();
      send_text();
      if (!drained_once && chars_sent >= DRAIN_AT) begin
        // sender pause until the block has handed back everything
        drained_once = 1'b1;
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tstk_pkg.sv
rtl/tstk_parser.sv
rtl/tstk_scale.sv
rtl/timestamp_text_to_ticks.sv
bench/timestamp_text_to_ticks_tb.sv
